FILE: src/dwl_pkg.sv
// ----------------------------------------------------------------------------
// dwl_pkg: shared types and constants of the word lookup unit
// Node word layout, command codes, queue request and back end state.
// ----------------------------------------------------------------------------
`default_nettype none

package dwl_pkg;

  localparam int NODE_WORDS_DEF   = 65536;
  localparam int MAX_WORD_LEN_DEF = 64;

  // wide enough for a 22-bit child index plus sibling offsets
  localparam int IDX_W    = 23;
  localparam int CHILD_W  = 22;
  localparam int ROOT_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int WORD_W   = 32;
  localparam int LETTER_W = 8;
  localparam int SPLIT_W  = 6;
  localparam int CNT_W    = 8;

  localparam int EOW_BIT     = 31;
  localparam int EOL_BIT     = 30;
  localparam int CHILD_HI    = 29;
  localparam int CHILD_LO    = 8;
  localparam int LETTER_HI   = 7;

  localparam logic [CNT_W-1:0] SIB_LAST = 8'hFF;

  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LETTER = 1'b1;

  typedef struct packed {
    logic                is_letter;
    logic                wr_ok;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } req_t;

  typedef enum logic {
    B_IDLE,
    B_CHECK
  } back_state_t;

endpackage

`default_nettype wire

FILE: src/dwl_in_if.sv
// ----------------------------------------------------------------------------
// dwl_in_if: input request channel
// Valid/ready channel carrying load and letter requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwl_in_if
  import dwl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ADDR_W-1:0]   node_addr;
  logic [WORD_W-1:0]   node_word;
  logic [LETTER_W-1:0] letter;
  logic                last_letter;

  modport source (
    output valid, cmd, node_addr, node_word, letter, last_letter,
    input  ready
  );

  modport sink (
    input  valid, cmd, node_addr, node_word, letter, last_letter,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/dwl_out_if.sv
// ----------------------------------------------------------------------------
// dwl_out_if: result channel
// Valid/ready channel carrying one lookup result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwl_out_if
  import dwl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               word_found;
  logic [SPLIT_W-1:0] split_pos;
  logic               walk_error;

  modport source (
    output valid, word_found, split_pos, walk_error,
    input  ready
  );

  modport sink (
    input  valid, word_found, split_pos, walk_error,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/dwl_ram.sv
// ----------------------------------------------------------------------------
// dwl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/dwl_front.sv
// ----------------------------------------------------------------------------
// dwl_front: request intake
// Accepts requests, classifies loads and letters, checks the write address
// and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dwl_front
  import dwl_pkg::*;
#(
  parameter int NODE_WORDS = NODE_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dwl_in_if.sink     in_ch,
  output      logic  q_valid,
  output      req_t  q_req,
  input  wire logic  q_pop
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  req_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wptr_r, wptr_nxt;
  logic [QPW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  req_t           req_in;
  logic           push;

  always_comb begin
    req_in.is_letter = (in_ch.cmd == CMD_LETTER);
    req_in.wr_ok     = (IDX_W'(in_ch.node_addr) < IDX_W'(NODE_WORDS));
    req_in.addr      = in_ch.node_addr;
    req_in.word      = in_ch.node_word;
    req_in.letter    = in_ch.letter;
    req_in.last      = in_ch.last_letter;
  end

  assign in_ch.ready = (count_r != QCW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_req       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + QPW'(1);
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + QPW'(1);
    end
    if (push && !q_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= req_in;
    end
  end

endmodule

`default_nettype wire

FILE: src/dwl_back.sv
// ----------------------------------------------------------------------------
// dwl_back: request execution
// Writes node words, walks sibling lists one node read per cycle, keeps
// per-word state and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwl_back
  import dwl_pkg::*;
#(
  parameter int NODE_WORDS   = NODE_WORDS_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire req_t                          q_req,
  output      logic                          q_pop,
  input  wire logic [ROOT_W-1:0]             root_node,
  output      logic                          ram_we,
  output      logic [$clog2(NODE_WORDS)-1:0] ram_waddr,
  output      logic [WORD_W-1:0]             ram_wdata,
  output      logic                          ram_re,
  output      logic [$clog2(NODE_WORDS)-1:0] ram_raddr,
  input  wire logic [WORD_W-1:0]             ram_rdata,
  dwl_out_if.source                          out_ch
);

  localparam int AW  = $clog2(NODE_WORDS);
  localparam int LPW = $clog2(MAX_WORD_LEN + 1);

  function automatic logic node_ok(input logic [IDX_W-1:0] i);
    return i < IDX_W'(NODE_WORDS);
  endfunction

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LETTER_W-1:0] it_letter_r, it_letter_nxt;
  logic                it_last_r, it_last_nxt;
  logic [CHILD_W-1:0]  cur_r, cur_nxt;
  logic [LPW-1:0]      lp_r, lp_nxt;
  logic                failed_r, failed_nxt;
  logic [LPW-1:0]      split_r, split_nxt;
  logic                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                found_r, found_nxt;
  logic [SPLIT_W-1:0]  spos_r, spos_nxt;
  logic                werr_r, werr_nxt;

  logic [IDX_W-1:0]    start_idx, idx_inc;
  logic [CHILD_W-1:0]  child;
  logic                slot_free, letter_go, load_go, skip, start_ok;
  logic                in_check, hit, eol, cont_ok, walk_go;
  logic                fin, fin_match, fin_err, fin_last;

  assign start_idx = (lp_r == '0) ? IDX_W'(root_node) : IDX_W'(cur_r);
  assign idx_inc   = idx_r + IDX_W'(1);
  assign child     = ram_rdata[CHILD_HI:CHILD_LO];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign letter_go = (state_r == B_IDLE) && q_valid && q_req.is_letter && slot_free;
  assign load_go   = (state_r == B_IDLE) && q_valid && !q_req.is_letter;
  assign skip      = failed_r || (lp_r >= LPW'(MAX_WORD_LEN));
  assign start_ok  = node_ok(start_idx);
  assign walk_go   = letter_go && !skip && start_ok;
  assign in_check  = (state_r == B_CHECK);
  assign hit       = (ram_rdata[LETTER_HI:0] == it_letter_r);
  assign eol       = ram_rdata[EOL_BIT];
  assign cont_ok   = !hit && !eol && (cnt_r != SIB_LAST) && node_ok(idx_inc);

  assign fin       = (letter_go && !walk_go) || (in_check && !cont_ok);
  assign fin_match = in_check && hit;
  assign fin_err   = (letter_go && !skip && !start_ok)
                   || (in_check && !hit && !eol && !cont_ok);
  assign fin_last  = letter_go ? q_req.last : it_last_r;
  assign q_pop     = load_go || letter_go;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (walk_go) begin
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (!cont_ok) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we        = load_go && q_req.wr_ok;
    ram_waddr     = AW'(IDX_W'(q_req.addr));
    ram_wdata     = q_req.word;
    ram_re        = walk_go || (in_check && cont_ok);
    ram_raddr     = walk_go ? AW'(start_idx) : AW'(idx_inc);
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    it_letter_nxt = it_letter_r;
    it_last_nxt   = it_last_r;
    cur_nxt       = cur_r;
    lp_nxt        = lp_r;
    failed_nxt    = failed_r;
    split_nxt     = split_r;
    err_nxt       = err_r;
    found_nxt     = found_r;
    spos_nxt      = spos_r;
    werr_nxt      = werr_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    if (letter_go) begin
      idx_nxt       = start_idx;
      cnt_nxt       = '0;
      it_letter_nxt = q_req.letter;
      it_last_nxt   = q_req.last;
    end else if (in_check && cont_ok) begin
      idx_nxt = idx_inc;
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (fin) begin
      if (fin_last) begin
        out_valid_nxt = 1'b1;
        found_nxt     = fin_match && ram_rdata[EOW_BIT];
        spos_nxt      = SPLIT_W'(split_r);
        werr_nxt      = err_r || fin_err;
        cur_nxt       = CHILD_W'(root_node);
        lp_nxt        = '0;
        failed_nxt    = 1'b0;
        split_nxt     = '0;
        err_nxt       = 1'b0;
      end else begin
        err_nxt = err_r || fin_err;
        if (lp_r < LPW'(MAX_WORD_LEN)) begin
          lp_nxt = lp_r + LPW'(1);
        end
        if (fin_match) begin
          if (ram_rdata[EOW_BIT] && (split_r == '0)) begin
            split_nxt = lp_r + LPW'(1);
          end
          if (child == '0) begin
            failed_nxt = 1'b1;
          end else begin
            cur_nxt = child;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cur_r       <= '0;
      lp_r        <= '0;
      failed_r    <= 1'b0;
      split_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      lp_r        <= lp_nxt;
      failed_r    <= failed_nxt;
      split_r     <= split_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    it_letter_r <= it_letter_nxt;
    it_last_r   <= it_last_nxt;
    found_r     <= found_nxt;
    spos_r      <= spos_nxt;
    werr_r      <= werr_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_found = found_r;
  assign out_ch.split_pos  = spos_r;
  assign out_ch.walk_error = werr_r;

endmodule

`default_nettype wire

FILE: src/dawg_word_lookup_unit.sv
// ----------------------------------------------------------------------------
// dawg_word_lookup_unit: word graph dictionary lookup
// Loads node words into node memory and looks words up letter by letter.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     cmd, node_addr, node_word, letter,
//                                 last_letter
//   out_ch   out  valid/ready     word_found, split_pos, walk_error
//   cfg      in   cfg_we          cfg_data (root_node)
//
// A load request writes one node word. A letter reads n sibling nodes
// (1 <= n <= 256), one node memory read per cycle on the single read port;
// a letter of a word that already failed reads none.
// The two-entry request queue holds each request in a register for the back end.
// Reset is synchronous; node memory is not cleared.
// A letter waits in the queue while the result register still holds a
// result that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dawg_word_lookup_unit
  import dwl_pkg::*;
#(
  parameter int NODE_WORDS   = NODE_WORDS_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ROOT_W-1:0] cfg_data,
  dwl_in_if.sink                 in_ch,
  dwl_out_if.source              out_ch
);

  localparam int AW = $clog2(NODE_WORDS);

  logic [ROOT_W-1:0] root_node_r;
  logic              q_valid, q_pop;
  req_t              q_req;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_node_r <= '0;
    end else if (cfg_we) begin
      root_node_r <= cfg_data;
    end
  end

  dwl_front #(
    .NODE_WORDS (NODE_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  dwl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dwl_back #(
    .NODE_WORDS   (NODE_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .root_node (root_node_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: src/dwl_checker.sv
// ----------------------------------------------------------------------------
// dwl_checker: result channel checks
// Watches the result port of the lookup unit; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwl_checker
  import dwl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               word_found,
  input wire logic [SPLIT_W-1:0] split_pos,
  input wire logic               walk_error
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(word_found) && $stable(split_pos) && $stable(walk_error))
    else $error("result changed while stalled");

  a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(word_found && walk_error))
    else $error("word found despite walk error");

endmodule

bind dawg_word_lookup_unit dwl_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_found (out_ch.word_found),
  .split_pos  (out_ch.split_pos),
  .walk_error (out_ch.walk_error)
);

`default_nettype wire
